### sv/assert_macros.svh
// Assertion helpers used by phase_angle_dimmer_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/pad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pad_pkg;

	localparam int CH_COUNT = 2;

	localparam logic OP_TICK       = 1'b0;
	localparam logic OP_ZERO_CROSS = 1'b1;

	// register index taken from paddr
	localparam logic REG_ACTIVE_CHANNELS = 1'b0;

	localparam logic [15:0] TICK_SAT  = 16'hFFFF;
	localparam logic [7:0]  COUNT_SAT = 8'hFF;
	localparam logic [6:0]  DELAY_SAT = 7'h7F;

	// per-channel view of the state after the current item
	typedef struct packed {
		logic       fire;
		logic       gate;
		logic [6:0] delay;
	} chan_nxt_t;

endpackage

`default_nettype wire

### sv/pad_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pad_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] level_a;
	logic [7:0] level_b;

	modport source (output valid, opcode, level_a, level_b, input ready);
	modport sink (input valid, opcode, level_a, level_b, output ready);
endinterface

interface pad_out_if;
	logic        valid;
	logic        ready;
	logic        gate_a;
	logic        gate_b;
	logic        half_cycle_active;
	logic [15:0] period_ticks;
	logic [6:0]  delay_a;
	logic [6:0]  delay_b;

	modport source (output valid, gate_a, gate_b, half_cycle_active, period_ticks,
		delay_a, delay_b, input ready);
	modport sink (input valid, gate_a, gate_b, half_cycle_active, period_ticks,
		delay_a, delay_b, output ready);
endinterface

`default_nettype wire

### sv/pad_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pad_cfg #(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [1:0]       req_fires
);
	import pad_pkg::*;

	logic [1:0] active_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 2'd2;
		end else if (wr_en) begin
			active_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ACTIVE_CHANNELS) begin
			prdata = {30'd0, active_q};
		end
	end

	// zero means one; more than the built channels means all of them
	always_comb begin
		if (active_q == 2'd0) begin
			req_fires = 2'd1;
		end else if (active_q > 2'(NUM_CHANNELS)) begin
			req_fires = 2'(NUM_CHANNELS);
		end else begin
			req_fires = active_q;
		end
	end

endmodule

`default_nettype wire

### sv/pad_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module pad_chan #(
	parameter int MAX_LEVEL = 100
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire logic          tick_en,
	input  wire logic [7:0]    level,
	output pad_pkg::chan_nxt_t nxt
);
	import pad_pkg::*;

	localparam logic [7:0] MaxLvl = 8'(MAX_LEVEL);

	logic [7:0] cnt_q;
	logic [7:0] latched_q;
	logic       fired_q;

	logic [7:0] lvl_c;
	logic [7:0] thr;
	logic       fire;
	logic       fired_d;
	logic [7:0] latched_d;

	assign lvl_c = (level > MaxLvl) ? MaxLvl : level;
	assign thr   = MaxLvl - lvl_c;
	assign fire  = tick_en && !fired_q && (cnt_q >= thr);

	assign fired_d   = clr ? 1'b0 : (fired_q || fire);
	assign latched_d = fire ? thr : latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			fired_q   <= 1'b0;
			latched_q <= '0;
		end else begin
			fired_q   <= fired_d;
			latched_q <= latched_d;
			if (clr) begin
				cnt_q <= '0;
			end else if (tick_en && !fired_q && !fire && cnt_q != COUNT_SAT) begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	// gate follows the fired flag within a half cycle
	assign nxt.fire  = fire;
	assign nxt.gate  = fired_d;
	assign nxt.delay = (latched_d > 8'(DELAY_SAT)) ? DELAY_SAT : latched_d[6:0];

endmodule

`default_nettype wire

### sv/phase_angle_dimmer_top.sv
// Two-channel phase-angle dimmer.
// item channel: one transfer per timer tick (opcode 0) or mains zero
//   crossing (opcode 1), carrying the level of both channels.
// result channel: one transfer per item, showing gates, half-cycle state,
//   last captured period and last latched delays after that item.
// APB port: register 0 at byte address 0 holds active_channels (2 bits).
//   pready is tied high; write only while the block is idle.
// Path: an accepted item is held in the input register, then in the result
//   register, from which it shows as a valid result; a result stall can hold
//   it in the input register in between.
// Throughput: one item per cycle while the result receiver does not stall;
//   the channel update is a compare and an increment between the two registers.
// When the result receiver stalls, the result register holds, the input
//   register takes at most one more item, and item.ready then stays low
//   until the waiting result is taken.
// Reset (arst_n low): fired flags off, half cycle idle, counters and period zero,
//   active_channels = 2, both registers empty; gate and delay outputs are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module phase_angle_dimmer_top #(
	parameter int MAX_LEVEL    = 100,
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pad_in_if.sink           item,
	pad_out_if.source        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pad_pkg::*;

	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] level_s1 [CH_COUNT];

	logic        out_valid_q;
	logic        gate_q [CH_COUNT];
	logic [6:0]  delay_q [CH_COUNT];
	logic        running_q;
	logic [15:0] period_q;
	logic [15:0] tick_q;
	logic [1:0]  total_q;

	logic       advance;
	logic       proc;
	logic       zc;
	logic       tick_en;
	logic [1:0] req_fires;
	logic [1:0] fire_cnt;
	logic [2:0] total_sum;
	logic [1:0] total_d;
	logic       running_d;
	logic       any_fire;

	chan_nxt_t nxt [CH_COUNT];

	assign advance    = !out_valid_q || result.ready;
	assign proc       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	assign zc      = proc && (opcode_s1 == OP_ZERO_CROSS);
	assign tick_en = proc && (opcode_s1 == OP_TICK) && running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1   <= item.opcode;
			level_s1[0] <= item.level_a;
			level_s1[1] <= item.level_b;
		end
	end

	pad_cfg #(.NUM_CHANNELS(NUM_CHANNELS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_fires (req_fires)
	);

	for (genvar ch = 0; ch < CH_COUNT; ch++) begin : g_ch
		if (ch < NUM_CHANNELS) begin : g_on
			pad_chan #(.MAX_LEVEL(MAX_LEVEL)) u_chan (
				.clk     (clk),
				.arst_n  (arst_n),
				.clr     (zc),
				.tick_en (tick_en),
				.level   (level_s1[ch]),
				.nxt     (nxt[ch])
			);
		end else begin : g_off
			assign nxt[ch] = '0;
		end
	end

	assign any_fire  = nxt[0].fire || nxt[1].fire;
	assign fire_cnt  = {1'b0, nxt[0].fire} + {1'b0, nxt[1].fire};
	assign total_sum = {1'b0, total_q} + {1'b0, fire_cnt};
	assign total_d   = zc ? 2'd0 : ((total_sum > 3'd3) ? 2'd3 : total_sum[1:0]);
	assign running_d = zc ? 1'b1 : (running_q && !(any_fire && total_d >= req_fires));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			total_q   <= '0;
			tick_q    <= '0;
			period_q  <= '0;
		end else if (proc) begin
			running_q <= running_d;
			total_q   <= total_d;
			if (zc) begin
				period_q <= tick_q;
				tick_q   <= '0;
			end else if (tick_q != TICK_SAT) begin
				tick_q <= tick_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < CH_COUNT; i++) begin
				gate_q[i]  <= nxt[i].gate;
				delay_q[i] <= nxt[i].delay;
			end
		end
	end

	assign result.valid             = out_valid_q;
	assign result.gate_a            = gate_q[0];
	assign result.gate_b            = gate_q[1];
	assign result.half_cycle_active = running_q;
	assign result.period_ticks      = period_q;
	assign result.delay_a           = delay_q[0];
	assign result.delay_b           = delay_q[1];

	`ASSERT_ALWAYS(a_total_bound, clk, total_q <= 2'(NUM_CHANNELS), "fired total above channel count")
	`ASSERT_CLK(a_zc_restart, clk, arst_n, zc |=> (running_q && total_q == 2'd0 && tick_q == 16'd0), "zero crossing did not restart half cycle")
	`ASSERT_CLK(a_proc_result, clk, arst_n, proc |=> out_valid_q, "processed item produced no result")
	`ASSERT_CLK(a_idle_no_fire, clk, arst_n, !running_q |-> !any_fire, "channel fired outside half cycle")

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import pad_pkg::*;

	localparam int MAX_LEVEL    = 100;
	localparam int NUM_CHANNELS = 2;
	localparam int IDLE_LIMIT   = 4000;
	localparam int REG_SPARE    = 1;	// no register behind this index
	localparam int LATENCY      = 2;

	typedef struct packed {
		logic        gate_a;
		logic        gate_b;
		logic        half_cycle_active;
		logic [15:0] period_ticks;
		logic [6:0]  delay_a;
		logic [6:0]  delay_b;
	} dimmer_view_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pad_in_if  item_ch ();
	pad_out_if result_ch ();

	phase_angle_dimmer_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted dimmer state
	logic [7:0]  mdl_delay_count [2];
	logic        mdl_fired [2];
	logic [1:0]  mdl_fired_total;
	logic        mdl_running;
	logic [15:0] mdl_ticks;
	logic [15:0] mdl_period;
	logic [7:0]  mdl_latched [2];
	logic        mdl_gate [2];
	logic [1:0]  mdl_active_channels;

	dimmer_view_t pending_views [$];

	int errors;
	int items_accepted;
	int views_checked;
	int half_cycles_run;
	int settings_used;

	int burst_left;
	int gap_max;
	int recv_mode;
	int hold_request;
	int hold_left;
	int stall_run;
	int recv_cycle;
	int idle_cycles;

	function automatic int unsigned fires_needed();
		int unsigned n;
		n = mdl_active_channels;
		if (n == 0) n = 1;
		if (n > NUM_CHANNELS) n = NUM_CHANNELS;
		return n;
	endfunction

	function automatic int unsigned fire_point(input logic [7:0] lvl);
		int unsigned clamped;
		clamped = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
		return (MAX_LEVEL - clamped) & 8'hFF;
	endfunction

	function automatic logic [6:0] delay_field(input logic [7:0] d);
		return (d > DELAY_SAT) ? DELAY_SAT : d[6:0];
	endfunction

	function automatic void reset_dimmer_model();
		for (int ch = 0; ch < 2; ch++) begin
			mdl_delay_count[ch] = '0;
			mdl_fired[ch] = 1'b0;
			mdl_latched[ch] = '0;
			mdl_gate[ch] = 1'b0;
		end
		mdl_fired_total = '0;
		mdl_running = 1'b0;
		mdl_ticks = '0;
		mdl_period = '0;
		mdl_active_channels = 2'd2;
	endfunction

	// Apply one item to the predicted state and queue the view it should produce.
	function automatic void advance_dimmer(input logic op, input logic [7:0] lvl_a,
			input logic [7:0] lvl_b);
		logic [7:0] lvl [2];
		int unsigned thr;
		dimmer_view_t view;
		lvl[0] = lvl_a;
		lvl[1] = lvl_b;
		if (op == OP_ZERO_CROSS) begin
			mdl_period = mdl_ticks;
			mdl_ticks = '0;
			for (int ch = 0; ch < 2; ch++) begin
				mdl_delay_count[ch] = '0;
				mdl_fired[ch] = 1'b0;
				mdl_gate[ch] = 1'b0;
			end
			mdl_fired_total = '0;
			mdl_running = 1'b1;
		end else begin
			if (mdl_ticks != TICK_SAT) mdl_ticks = mdl_ticks + 16'd1;
			if (mdl_running) begin
				// a later channel is still scanned after an earlier one ends the cycle
				for (int ch = 0; ch < NUM_CHANNELS && ch < 2; ch++) begin
					thr = fire_point(lvl[ch]);
					if (!mdl_fired[ch]) begin
						if (mdl_delay_count[ch] >= thr) begin
							mdl_gate[ch] = 1'b1;
							mdl_latched[ch] = thr[7:0];
							mdl_fired[ch] = 1'b1;
							if (mdl_fired_total != 2'd3) mdl_fired_total = mdl_fired_total + 2'd1;
							if (mdl_fired_total >= fires_needed()) mdl_running = 1'b0;
						end else if (mdl_delay_count[ch] != COUNT_SAT) begin
							mdl_delay_count[ch] = mdl_delay_count[ch] + 8'd1;
						end
					end
				end
			end
		end
		view.gate_a = mdl_gate[0];
		view.gate_b = mdl_gate[1];
		view.half_cycle_active = mdl_running;
		view.period_ticks = mdl_period;
		view.delay_a = delay_field(mdl_latched[0]);
		view.delay_b = delay_field(mdl_latched[1]);
		pending_views.push_back(view);
	endfunction

	// ---------------------------------------------------------------- result side

	always @(negedge clk) begin
		recv_cycle <= recv_cycle + 1;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ch.ready = 1'b0;
		end else begin
			case (recv_mode)
				0: begin
					result_ch.ready = 1'b1;
				end
				1: begin
					result_ch.ready = ($urandom_range(0, 3) != 0);
				end
				2: begin
					if (stall_run > 0) begin
						stall_run = stall_run - 1;
						result_ch.ready = 1'b0;
					end else if ($urandom_range(0, 11) == 0) begin
						stall_run = $urandom_range(1, 14);
						result_ch.ready = 1'b0;
					end else begin
						result_ch.ready = 1'b1;
					end
				end
				default: begin
					result_ch.ready = (recv_cycle % 7) >= 3;
				end
			endcase
		end
	end

	dimmer_view_t seen_view;
	dimmer_view_t want_view;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen_view.gate_a = result_ch.gate_a;
			seen_view.gate_b = result_ch.gate_b;
			seen_view.half_cycle_active = result_ch.half_cycle_active;
			seen_view.period_ticks = result_ch.period_ticks;
			seen_view.delay_a = result_ch.delay_a;
			seen_view.delay_b = result_ch.delay_b;
			if (pending_views.size() == 0) begin
				errors = errors + 1;
				if (errors <= 10)
					$display("%0t: result transfer with nothing pending: %p", $realtime, seen_view);
			end else begin
				want_view = pending_views.pop_front();
				views_checked = views_checked + 1;
				if (seen_view.gate_a !== want_view.gate_a
						|| seen_view.gate_b !== want_view.gate_b
						|| seen_view.half_cycle_active !== want_view.half_cycle_active
						|| seen_view.period_ticks !== want_view.period_ticks
						|| seen_view.delay_a !== want_view.delay_a
						|| seen_view.delay_b !== want_view.delay_b) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("%0t: result %0d mismatch: expected gates %b%b active %b period %0d delays %0d/%0d, got gates %b%b active %b period %0d delays %0d/%0d",
							$realtime, views_checked,
							want_view.gate_a, want_view.gate_b, want_view.half_cycle_active,
							want_view.period_ticks, want_view.delay_a, want_view.delay_b,
							seen_view.gate_a, seen_view.gate_b, seen_view.half_cycle_active,
							seen_view.period_ticks, seen_view.delay_a, seen_view.delay_b);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending_views.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- item side

	task automatic send_item(input logic op, input logic [7:0] lvl_a, input logic [7:0] lvl_b);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) gap = $urandom_range(0, gap_max);
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.opcode = op;
		item_ch.level_a = lvl_a;
		item_ch.level_b = lvl_b;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		advance_dimmer(op, lvl_a, lvl_b);
		items_accepted = items_accepted + 1;
	endtask

	task automatic release_items();
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_views.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [31:0] data);
		release_items();
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 3'(idx * 4);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_ACTIVE_CHANNELS) mdl_active_channels = data[1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_active_channels(input logic [1:0] value);
		apb_write(REG_ACTIVE_CHANNELS, ($urandom() & ~32'h3) | value);
		settings_used = settings_used + 1;
	endtask

	function automatic logic [7:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 8'($urandom_range(70, 255));
		if (r < 70) return 8'($urandom_range(0, 255));
		if (r < 85) begin
			case ($urandom_range(0, 5))
				0: return 8'd0;
				1: return 8'd1;
				2: return 8'd99;
				3: return 8'd100;
				4: return 8'd101;
				default: return 8'd255;
			endcase
		end
		return 8'($urandom_range(0, 69));
	endfunction

	// zero crossing, then a run of ticks; levels may wander within the cycle
	task automatic run_half_cycle(input int n_ticks, input logic [7:0] lvl_a,
			input logic [7:0] lvl_b, input bit wander);
		logic [7:0] la;
		logic [7:0] lb;
		la = lvl_a;
		lb = lvl_b;
		send_item(OP_ZERO_CROSS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		half_cycles_run = half_cycles_run + 1;
		for (int i = 0; i < n_ticks; i++) begin
			if (wander && $urandom_range(0, 9) == 0) la = pick_level();
			if (wander && $urandom_range(0, 9) == 0) lb = pick_level();
			send_item(OP_TICK, la, lb);
		end
	endtask

	task automatic random_traffic(input int n_items);
		int stop_at;
		int r;
		int span;
		logic [7:0] la;
		logic [7:0] lb;
		stop_at = items_accepted + n_items;
		while (items_accepted < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				la = pick_level();
				lb = pick_level();
				span = fire_point(la) > fire_point(lb) ? fire_point(la) : fire_point(lb);
				run_half_cycle($urandom_range(0, span + 4), la, lb, $urandom_range(0, 3) == 0);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 5))
					send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
			end else begin
				// cut short by an early crossing
				run_half_cycle($urandom_range(0, 3), pick_level(), 8'($urandom_range(0, 40)),
					1'b0);
			end
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_cases();
		recv_mode = 0;
		gap_max = 0;
		// ticks before any crossing only move the tick count
		send_item(OP_TICK, 8'h00, 8'h00);
		send_item(OP_TICK, 8'hFF, 8'hFF);
		// level above the maximum clamps to a zero delay; both fire on the same tick
		send_item(OP_ZERO_CROSS, 8'hFF, 8'hFF);
		send_item(OP_TICK, 8'hFF, 8'hFF);
		send_item(OP_TICK, 8'hAA, 8'h55);
		send_item(OP_ZERO_CROSS, 8'h55, 8'hAA);
		send_item(OP_TICK, 8'd99, 8'd98);
		send_item(OP_TICK, 8'd99, 8'd98);
		send_item(OP_TICK, 8'd99, 8'd98);
		send_item(OP_TICK, 8'd99, 8'd98);
		send_item(OP_ZERO_CROSS, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd101, 8'd100);
		send_item(OP_TICK, 8'd0, 8'd0);
		// one channel needed: channel 0 ends the cycle, channel 1 still fires that tick
		set_active_channels(2'd1);
		send_item(OP_ZERO_CROSS, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd100, 8'd100);
		// one channel needed: the slow channel never gets its turn
		send_item(OP_ZERO_CROSS, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd100, 8'd0);
		send_item(OP_TICK, 8'd100, 8'd0);
		send_item(OP_TICK, 8'd100, 8'd0);
		// zero and three are read as one and two
		set_active_channels(2'd0);
		send_item(OP_ZERO_CROSS, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd100, 8'd0);
		set_active_channels(2'd3);
		send_item(OP_ZERO_CROSS, 8'd0, 8'd0);
		send_item(OP_TICK, 8'd100, 8'd97);
		send_item(OP_TICK, 8'd100, 8'd97);
		send_item(OP_TICK, 8'd100, 8'd97);
		send_item(OP_TICK, 8'd100, 8'd97);
		release_items();
	endtask

	// longest delay: level zero fires only after the full count
	task automatic test_full_delay_range();
		set_active_channels(2'd2);
		recv_mode = 0;
		gap_max = 0;
		send_item(OP_ZERO_CROSS, 8'd0, 8'd3);
		repeat (110) send_item(OP_TICK, 8'd0, 8'd3);
		send_item(OP_ZERO_CROSS, 8'd255, 8'd0);
		send_item(OP_ZERO_CROSS, 8'd0, 8'd0);
		release_items();
	endtask

	task automatic test_register_settings();
		logic [1:0] settings [4];
		settings[0] = 2'd1;
		settings[1] = 2'd0;
		settings[2] = 2'd3;
		settings[3] = 2'd2;
		for (int i = 0; i < 4; i++) begin
			set_active_channels(settings[i]);
			recv_mode = i;
			gap_max = (i == 0) ? 0 : (i * 4);
			random_traffic(350);
			if (i == 1) apb_write(REG_SPARE, $urandom());
		end
		release_items();
	endtask

	task automatic test_output_backpressure();
		set_active_channels(2'd2);
		recv_mode = 0;
		gap_max = 0;
		send_item(OP_ZERO_CROSS, 8'd60, 8'd80);
		hold_request = 200;
		for (int i = 0; i < 60; i++) send_item(OP_TICK, 8'd60, 8'd80);
		// sender waits for every result before going on
		release_items();
		wait_drained();
		recv_mode = 2;
		gap_max = 6;
		random_traffic(150);
		hold_request = 120;
		random_traffic(150);
		release_items();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_TICK;
		item_ch.level_a = '0;
		item_ch.level_b = '0;
		result_ch.ready = 1'b0;
		errors = 0;
		items_accepted = 0;
		views_checked = 0;
		half_cycles_run = 0;
		settings_used = 0;
		burst_left = 0;
		gap_max = 0;
		recv_mode = 0;
		hold_request = 0;
		hold_left = 0;
		stall_run = 0;
		recv_cycle = 0;
		idle_cycles = 0;
		reset_dimmer_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_full_delay_range();
		test_register_settings();
		test_output_backpressure();

		wait_drained();
		repeat (LATENCY * 4) @(posedge clk);
		$display("covered %0d items, %0d results, %0d half cycles, %0d channel settings",
			items_accepted, views_checked, half_cycles_run, settings_used);
		$display("including the full delay range, clamped levels and output stalls; %0d errors",
			errors);
		if (errors == 0 && pending_views.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
